// ----- src/fpc_pkg.sv -----
// Frame period calibrator: shared types and constants.
// No dependencies; used by the channel interfaces and the core module.
package fpc_pkg;

   localparam int ELAPSED_W  = 24;
   localparam int NOMINAL_W  = 23;
   localparam int OUT_W      = 24;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [NOMINAL_W-1:0] NOMINAL_RESET = 23'd16667;

   // register index, taken from paddr[2]
   localparam logic REG_NOMINAL = 1'b0;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_DIVIDE,
      ST_CORRECT
   } state_type;

endpackage

// ----- src/fpc_if.sv -----
// Frame period calibrator: request and response channel interfaces.
// Depends on fpc_pkg for the payload widths.
interface fpc_req_if;
   logic                           valid;
   logic                           ready;
   logic [fpc_pkg::ELAPSED_W-1:0]  elapsed_us;

   modport source (output valid, output elapsed_us, input ready);
   modport sink   (input valid, input elapsed_us, output ready);
endinterface

interface fpc_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [fpc_pkg::OUT_W-1:0]  next_timeout_us;
   logic [fpc_pkg::OUT_W-1:0]  average_us;
   logic                       fell_back;

   modport source (output valid, output next_timeout_us, output average_us,
                   output fell_back, input ready);
   modport sink   (input valid, input next_timeout_us, input average_us,
                   input fell_back, output ready);
endinterface

// ----- src/frame_period_calibrator_core.sv -----
// Frame period calibrator top level: sample ring, running sum, bit-serial divider.
// Depends on fpc_pkg, fpc_if (fpc_req_if, fpc_rsp_if) and fpc_ram.
//
// Channel  Direction  Handshake            Payload
// req_bus  in         valid/ready          elapsed_us
// rsp_bus  out        valid/ready          next_timeout_us, average_us, fell_back
// csr_*    in         APB, pready tied hi  nominal_interval at byte 0
//
// Each request passes through accept, ring read and sum update, then one
// quotient bit per cycle from the restoring divider.
// Synchronous reset clears the ring position, count and sum, and reloads the
// nominal interval with its default.
// A waiting response does not block the next request; the divider result is
// held until the output register is free.
module frame_period_calibrator_core #(
   parameter int WINDOW = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   fpc_req_if.sink                             req_bus,
   fpc_rsp_if.source                           rsp_bus,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [fpc_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [fpc_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [fpc_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);

   localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int FILL_W = $clog2(WINDOW + 1);
   localparam int SUM_W  = fpc_pkg::ELAPSED_W + $clog2(WINDOW);
   localparam int CNT_W  = $clog2(SUM_W);
   localparam logic [FILL_W-1:0] WINDOW_FILL = FILL_W'(WINDOW);
   localparam logic [SLOT_W-1:0] SLOT_LAST   = SLOT_W'(WINDOW - 1);
   localparam logic [CNT_W-1:0]  DIV_LAST    = CNT_W'(SUM_W - 1);

   fpc_pkg::state_type state_ff, state_in;

   logic [fpc_pkg::NOMINAL_W-1:0] nominal_ff, nominal_in;
   logic [SLOT_W-1:0]             slot_ff, slot_in;
   logic [FILL_W-1:0]             fill_ff, fill_in;
   logic [SUM_W-1:0]              sum_ff, sum_in;
   logic [fpc_pkg::ELAPSED_W-1:0] sample_ff, sample_in;
   logic [FILL_W-1:0]             rem_ff, rem_in;
   logic [SUM_W-1:0]              quo_ff, quo_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [fpc_pkg::OUT_W-1:0]     timeout_ff, timeout_in;
   logic [fpc_pkg::OUT_W-1:0]     average_ff, average_in;
   logic                          fell_ff, fell_in;

   logic                          req_accept;
   logic                          csr_write;
   logic                          full;
   logic [fpc_pkg::ELAPSED_W-1:0] old_sample;
   logic [FILL_W:0]               div_shift;
   logic [FILL_W:0]               div_diff;
   logic                          div_ge;
   logic [fpc_pkg::OUT_W:0]       corr;
   logic                          corr_fall;
   logic                          out_free;

   // FSM control outputs
   logic                          ctl_ready;
   logic                          ctl_load;
   logic                          ctl_divide;
   logic                          ctl_emit;

   fpc_ram #(
      .WIDTH (fpc_pkg::ELAPSED_W),
      .DEPTH (WINDOW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ctl_load),
      .wr_addr (slot_ff),
      .wr_data (sample_ff),
      .rd_en   (req_accept),
      .rd_addr (slot_ff),
      .rd_data (old_sample)
   );

   assign req_accept = req_bus.valid && ctl_ready;
   assign req_bus.ready = ctl_ready;
   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   // config port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite
                       && (csr_paddr[2] == fpc_pkg::REG_NOMINAL);
   assign csr_prdata = (csr_paddr[2] == fpc_pkg::REG_NOMINAL)
                       ? {{(fpc_pkg::CSR_DATA_W - fpc_pkg::NOMINAL_W){1'b0}}, nominal_ff}
                       : '0;
   assign nominal_in = csr_write ? csr_pwdata[fpc_pkg::NOMINAL_W-1:0] : nominal_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fpc_pkg::ST_IDLE: begin
            if (req_bus.valid) begin
               state_in = fpc_pkg::ST_LOAD;
            end
         end
         fpc_pkg::ST_LOAD: begin
            state_in = fpc_pkg::ST_DIVIDE;
         end
         fpc_pkg::ST_DIVIDE: begin
            if (cnt_ff == DIV_LAST) begin
               state_in = fpc_pkg::ST_CORRECT;
            end
         end
         fpc_pkg::ST_CORRECT: begin
            if (out_free) begin
               state_in = fpc_pkg::ST_IDLE;
            end
         end
         default: state_in = fpc_pkg::ST_IDLE;
      endcase
   end

   // FSM outputs
   always_comb begin
      ctl_ready  = 1'b0;
      ctl_load   = 1'b0;
      ctl_divide = 1'b0;
      ctl_emit   = 1'b0;
      unique case (state_ff)
         fpc_pkg::ST_IDLE:    ctl_ready  = 1'b1;
         fpc_pkg::ST_LOAD:    ctl_load   = 1'b1;
         fpc_pkg::ST_DIVIDE:  ctl_divide = 1'b1;
         fpc_pkg::ST_CORRECT: ctl_emit   = out_free;
         default: ;
      endcase
   end

   // ring position, count and running sum
   assign full = (fill_ff == WINDOW_FILL);

   always_comb begin
      sample_in = req_accept ? req_bus.elapsed_us : sample_ff;
      slot_in   = slot_ff;
      fill_in   = fill_ff;
      sum_in    = sum_ff;
      if (ctl_load) begin
         slot_in = (slot_ff == SLOT_LAST) ? '0 : slot_ff + 1'b1;
         fill_in = full ? fill_ff : fill_ff + 1'b1;
         sum_in  = sum_ff
                   - (full ? SUM_W'(old_sample) : '0)
                   + SUM_W'(sample_ff);
      end
   end

   // restoring divider, one quotient bit per cycle
   assign div_shift = {rem_ff, quo_ff[SUM_W-1]};
   assign div_diff  = div_shift - {1'b0, fill_ff};
   assign div_ge    = !div_diff[FILL_W];

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      if (ctl_load) begin
         rem_in = '0;
         quo_in = sum_in;
         cnt_in = '0;
      end else if (ctl_divide) begin
         rem_in = div_ge ? div_diff[FILL_W-1:0] : div_shift[FILL_W-1:0];
         quo_in = {quo_ff[SUM_W-2:0], div_ge};
         cnt_in = cnt_ff + 1'b1;
      end
   end

   // 2 * nominal - average, falling back to nominal when not positive
   assign corr = {1'b0, nominal_ff, 1'b0} - {1'b0, quo_ff[fpc_pkg::OUT_W-1:0]};
   assign corr_fall = corr[fpc_pkg::OUT_W] || (corr == '0);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      timeout_in   = timeout_ff;
      average_in   = average_ff;
      fell_in      = fell_ff;
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (ctl_emit) begin
         rsp_valid_in = 1'b1;
         timeout_in   = corr_fall ? {1'b0, nominal_ff} : corr[fpc_pkg::OUT_W-1:0];
         average_in   = quo_ff[fpc_pkg::OUT_W-1:0];
         fell_in      = corr_fall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fpc_pkg::ST_IDLE;
         nominal_ff   <= fpc_pkg::NOMINAL_RESET;
         slot_ff      <= '0;
         fill_ff      <= '0;
         sum_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         nominal_ff   <= nominal_in;
         slot_ff      <= slot_in;
         fill_ff      <= fill_in;
         sum_ff       <= sum_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff  <= sample_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      timeout_ff <= timeout_in;
      average_ff <= average_in;
      fell_ff    <= fell_in;
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.next_timeout_us = timeout_ff;
   assign rsp_bus.average_us      = average_ff;
   assign rsp_bus.fell_back       = fell_ff;

   // checks
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= WINDOW_FILL)
      else $error("sample count beyond window");

   a_slot_tracks_fill: assert property (@(posedge clock) disable iff (reset)
      !full |-> (FILL_W'(slot_ff) == fill_ff))
      else $error("ring position out of step with count while filling");

   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff == fpc_pkg::ST_LOAD)
      else $error("accepted request not loaded");

   a_rsp_from_correct: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == fpc_pkg::ST_CORRECT)
      else $error("response raised outside correction step");

   a_timeout_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !fell_ff) |-> (timeout_ff != '0))
      else $error("zero timeout without fallback");

endmodule

// ----- src/fpc_ram.sv -----
// Frame period calibrator: generic single-write, single-read RAM, registered read.
// No dependencies.
module fpc_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
